// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the point-to-segment distance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define PSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define PSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/psd_pkg.sv =====
// Shared types and constants for the point-to-segment distance block.
`default_nettype none

package psd_pkg;

    // Width of the configuration register index
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 2'd3;

    // How the projection ratio is settled for one word
    typedef enum logic [1:0] {
        SAT_NONE,   // 0 < num < den: quotient from the divider chain
        SAT_ZERO,   // num <= 0 or zero-length segment
        SAT_ONE     // num >= den
    } t_sat;

    typedef struct packed {
        logic valid;
        t_sat sat;
    } t_ratio_ctl;

endpackage

`default_nettype wire

// ===== hdl/psd_cell.sv =====
// One restoring-division cell: produces one quotient bit per word and passes it on.
`default_nettype none

module psd_cell import psd_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [2*COORD_BITS:0]     i_den,
    input  wire t_ratio_ctl                i_ctl,
    input  wire logic [2*COORD_BITS:0]     i_rem,
    input  wire logic [FRAC_BITS:0]        i_q,
    input  wire logic [COORD_BITS:0]       i_ex,
    input  wire logic [COORD_BITS:0]       i_ey,
    output t_ratio_ctl                     o_ctl,
    output logic [2*COORD_BITS:0]          o_rem,
    output logic [FRAC_BITS:0]             o_q,
    output logic [COORD_BITS:0]            o_ex,
    output logic [COORD_BITS:0]            o_ey
);

    localparam int DEN_W = 2*COORD_BITS + 1;
    localparam int REM_W = DEN_W + 1;
    localparam int Q_W   = FRAC_BITS + 1;

    logic [REM_W-1:0] w_rem2;
    logic [REM_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;

    t_ratio_ctl       r_ctl;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_q;
    logic [COORD_BITS:0] r_ex;
    logic [COORD_BITS:0] r_ey;

    // remainder stays below den, so the doubled value fits one extra bit
    assign w_rem2 = {i_rem, 1'b0};
    assign w_diff = {1'b0, w_rem2} - {2'b00, i_den};
    assign w_ge   = ~w_diff[REM_W];

    always_comb begin
        if (w_ge) begin
            n_rem = w_diff[DEN_W-1:0];
        end else begin
            n_rem = w_rem2[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= {i_q[Q_W-2:0], w_ge};
        r_ex  <= i_ex;
        r_ey  <= i_ey;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_q   = r_q;
    assign o_ex  = r_ex;
    assign o_ey  = r_ey;

endmodule

`default_nettype wire

// ===== hdl/psd_front.sv =====
// Front end: segment deltas, squared length, dot product and ratio classification.
`default_nettype none

module psd_front import psd_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [COORD_BITS-1:0]     i_point_x,
    input  wire logic [COORD_BITS-1:0]     i_point_y,
    input  wire logic [COORD_BITS-1:0]     i_start_x,
    input  wire logic [COORD_BITS-1:0]     i_start_y,
    input  wire logic [COORD_BITS-1:0]     i_end_x,
    input  wire logic [COORD_BITS-1:0]     i_end_y,
    output t_ratio_ctl                     o_ctl,
    output logic [2*COORD_BITS:0]          o_rem,
    output logic [COORD_BITS:0]            o_ex,
    output logic [COORD_BITS:0]            o_ey,
    output logic signed [COORD_BITS:0]     o_dx,
    output logic signed [COORD_BITS:0]     o_dy,
    output logic [2*COORD_BITS:0]          o_den
);

    localparam int C      = COORD_BITS;
    localparam int EXT_W  = C + 1;
    localparam int PROD_W = 2*C + 2;
    localparam int NUM_W  = 2*C + 3;
    localparam int DEN_W  = 2*C + 1;
    localparam int SQ_W   = 2*C;

    logic signed [EXT_W-1:0]  n_dx, n_dy, n_ex, n_ey;
    logic signed [PROD_W-1:0] w_dx2, w_dy2, w_px, w_py;
    logic signed [NUM_W-1:0]  w_num;
    logic                     w_pos, w_ge;
    t_ratio_ctl               n_ctl;

    // segment terms, refreshed every cycle from the config registers
    logic signed [EXT_W-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]         r_dx2, r_dy2;
    logic [DEN_W-1:0]        r_den;

    logic                     r0_valid, r1_valid;
    logic signed [EXT_W-1:0]  r0_ex, r0_ey, r1_ex, r1_ey;
    logic signed [PROD_W-1:0] r1_px, r1_py;
    t_ratio_ctl               r2_ctl;
    logic [DEN_W-1:0]         r2_rem;
    logic [EXT_W-1:0]         r2_ex, r2_ey;

    assign n_dx  = {i_end_x[C-1], i_end_x} - {i_start_x[C-1], i_start_x};
    assign n_dy  = {i_end_y[C-1], i_end_y} - {i_start_y[C-1], i_start_y};
    assign n_ex  = {i_point_x[C-1], i_point_x} - {i_start_x[C-1], i_start_x};
    assign n_ey  = {i_point_y[C-1], i_point_y} - {i_start_y[C-1], i_start_y};
    assign w_dx2 = n_dx * n_dx;
    assign w_dy2 = n_dy * n_dy;
    assign w_px  = r0_ex * r_dx;
    assign w_py  = r0_ey * r_dy;

    assign w_num = {r1_px[PROD_W-1], r1_px} + {r1_py[PROD_W-1], r1_py};
    assign w_pos = ~w_num[NUM_W-1] && (w_num != '0);
    assign w_ge  = w_num[NUM_W-2:0] >= {1'b0, r_den};

    always_comb begin
        n_ctl.valid = r1_valid;
        if ((r_den == '0) || !w_pos) begin
            n_ctl.sat = SAT_ZERO;
        end else if (w_ge) begin
            n_ctl.sat = SAT_ONE;
        end else begin
            n_ctl.sat = SAT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx     <= '0;
            r_dy     <= '0;
            r_dx2    <= '0;
            r_dy2    <= '0;
            r_den    <= '0;
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_ctl   <= '0;
        end else begin
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_dx2    <= w_dx2[SQ_W-1:0];
            r_dy2    <= w_dy2[SQ_W-1:0];
            r_den    <= {1'b0, r_dx2} + {1'b0, r_dy2};
            r0_valid <= i_accept;
            r1_valid <= r0_valid;
            r2_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_ex  <= n_ex;
        r0_ey  <= n_ey;
        r1_px  <= w_px;
        r1_py  <= w_py;
        r1_ex  <= r0_ex;
        r1_ey  <= r0_ey;
        // only meaningful for SAT_NONE, where 0 < num < den
        r2_rem <= w_num[DEN_W-1:0];
        r2_ex  <= r1_ex;
        r2_ey  <= r1_ey;
    end

    assign o_ctl = r2_ctl;
    assign o_rem = r2_rem;
    assign o_ex  = r2_ex;
    assign o_ey  = r2_ey;
    assign o_dx  = r_dx;
    assign o_dy  = r_dy;
    assign o_den = r_den;

endmodule

`default_nettype wire

// ===== hdl/psd_back.sv =====
// Back end: ratio rounding, closest point, offset and squared distance.
`default_nettype none
`include "assert_macros.svh"

module psd_back import psd_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_ratio_ctl                i_ctl,
    input  wire logic [FRAC_BITS:0]        i_q,
    input  wire logic [COORD_BITS:0]       i_ex,
    input  wire logic [COORD_BITS:0]       i_ey,
    input  wire logic signed [COORD_BITS:0] i_dx,
    input  wire logic signed [COORD_BITS:0] i_dy,
    input  wire logic [COORD_BITS-1:0]     i_start_x,
    input  wire logic [COORD_BITS-1:0]     i_start_y,
    output logic                           o_valid,
    output logic [FRAC_BITS:0]             o_ratio,
    output logic [COORD_BITS-1:0]          o_near_x,
    output logic [COORD_BITS-1:0]          o_near_y,
    output logic [COORD_BITS:0]            o_offset_x,
    output logic [COORD_BITS:0]            o_offset_y,
    output logic [2*COORD_BITS:0]          o_dist_sqr
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int Q_W   = F + 1;
    localparam int EXT_W = C + 1;
    localparam int PW    = F + C + 3;
    localparam int OFF_P = 2*C + 2;
    localparam int SQ_W  = 2*C;
    localparam logic [Q_W-1:0]       ONE_Q = {1'b1, {F{1'b0}}};
    localparam logic signed [PW-1:0] HALF  = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic [Q_W:0]            w_round;
    logic [Q_W-1:0]          n_ratio;
    logic signed [PW-1:0]    w_px, w_py, w_sx, w_sy, w_rxf, w_ryf;
    logic signed [EXT_W-1:0] w_rx, w_ry;
    logic signed [OFF_P-1:0] w_sqx, w_sqy;

    logic                    r3_valid, r4_valid, r5_valid, r6_valid, r7_valid;
    logic [Q_W-1:0]          r3_ratio, r4_ratio, r5_ratio, r6_ratio, r7_ratio;
    logic signed [EXT_W-1:0] r3_ex, r3_ey, r4_ex, r4_ey;
    logic signed [PW-1:0]    r4_px, r4_py;
    logic [C-1:0]            r5_near_x, r5_near_y, r6_near_x, r6_near_y;
    logic [C-1:0]            r7_near_x, r7_near_y;
    logic signed [EXT_W-1:0] r5_off_x, r5_off_y, r6_off_x, r6_off_y;
    logic [EXT_W-1:0]        r7_off_x, r7_off_y;
    logic [SQ_W-1:0]         r6_sq_x, r6_sq_y;
    logic [SQ_W:0]           r7_dist;

    // round to nearest, ties up: drop the extra quotient bit after adding one
    assign w_round = {1'b0, i_q} + {{Q_W{1'b0}}, 1'b1};

    always_comb begin
        case (i_ctl.sat)
            SAT_NONE: n_ratio = w_round[Q_W:1];
            SAT_ZERO: n_ratio = '0;
            SAT_ONE:  n_ratio = ONE_Q;
            default:  n_ratio = '0;
        endcase
    end

    assign w_px = $signed({1'b0, r3_ratio}) * i_dx;
    assign w_py = $signed({1'b0, r3_ratio}) * i_dy;

    // arithmetic shift gives the floor, so ties go up
    assign w_sx  = r4_px + HALF;
    assign w_sy  = r4_py + HALF;
    assign w_rxf = w_sx >>> F;
    assign w_ryf = w_sy >>> F;
    assign w_rx  = w_rxf[EXT_W-1:0];
    assign w_ry  = w_ryf[EXT_W-1:0];

    assign w_sqx = r5_off_x * r5_off_x;
    assign w_sqy = r5_off_y * r5_off_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else begin
            r3_valid <= i_ctl.valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_ratio  <= n_ratio;
        r3_ex     <= i_ex;
        r3_ey     <= i_ey;

        r4_ratio  <= r3_ratio;
        r4_px     <= w_px;
        r4_py     <= w_py;
        r4_ex     <= r3_ex;
        r4_ey     <= r3_ey;

        r5_ratio  <= r4_ratio;
        r5_near_x <= i_start_x + w_rx[C-1:0];
        r5_near_y <= i_start_y + w_ry[C-1:0];
        r5_off_x  <= w_rx - r4_ex;
        r5_off_y  <= w_ry - r4_ey;

        r6_ratio  <= r5_ratio;
        r6_near_x <= r5_near_x;
        r6_near_y <= r5_near_y;
        r6_off_x  <= r5_off_x;
        r6_off_y  <= r5_off_y;
        r6_sq_x   <= w_sqx[SQ_W-1:0];
        r6_sq_y   <= w_sqy[SQ_W-1:0];

        r7_ratio  <= r6_ratio;
        r7_near_x <= r6_near_x;
        r7_near_y <= r6_near_y;
        r7_off_x  <= r6_off_x;
        r7_off_y  <= r6_off_y;
        r7_dist   <= {1'b0, r6_sq_x} + {1'b0, r6_sq_y};
    end

    assign o_valid    = r7_valid;
    assign o_ratio    = r7_ratio;
    assign o_near_x   = r7_near_x;
    assign o_near_y   = r7_near_y;
    assign o_offset_x = r7_off_x;
    assign o_offset_y = r7_off_y;
    assign o_dist_sqr = r7_dist;

    `PSD_ASSERT_IMP(a_ratio_range, i_clk, i_rst_n, r3_valid, r3_ratio <= ONE_Q, "ratio above one")

endmodule

`default_nettype wire

// ===== hdl/point_segment_distance_top.sv =====
// Top level of the point-to-segment distance block: config registers and divider chain.
//
// Usage:
//   Segment end points are written through the config channel (i_cfg_valid,
//   o_cfg_ready, i_cfg_index, i_cfg_data); index 0..3 selects start x, start y,
//   end x, end y. Write them only while no query is in flight.
//   A query point is taken on each edge with i_start high and o_busy low.
//   o_busy is high in reset and until the first clock edge after it; from then on
//   one point can enter every cycle.
//   Each point yields one word on the result ports, flagged by a one-cycle
//   o_valid strobe. The pipeline is a row of FRAC_BITS + 1 division cells,
//   one quotient bit per cell, with the multiply and add stages around it.
//   Results come out in query order; the receiver cannot stall, so it must
//   take every strobed word. Throughput is one point per cycle.
//   Reset clears the segment to all zero and flushes the pipeline.
//
`default_nettype none
`include "assert_macros.svh"

module point_segment_distance_top import psd_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [COORD_BITS-1:0]     i_point_x,
    input  wire logic [COORD_BITS-1:0]     i_point_y,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [COORD_BITS-1:0]     i_cfg_data,
    output logic                           o_valid,
    output logic [FRAC_BITS:0]             o_ratio,
    output logic [COORD_BITS-1:0]          o_near_x,
    output logic [COORD_BITS-1:0]          o_near_y,
    output logic [COORD_BITS:0]            o_offset_x,
    output logic [COORD_BITS:0]            o_offset_y,
    output logic [2*COORD_BITS:0]          o_dist_sqr
);

    localparam int C     = COORD_BITS;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int DEN_W = 2*C + 1;
    localparam int LAT   = FRAC_BITS + 9;

    logic            r_busy;
    logic            w_accept;
    logic            w_div_live;
    logic [C-1:0]    r_start_x, r_start_y, r_end_x, r_end_y;

    logic signed [C:0] w_dx, w_dy;
    logic [DEN_W-1:0]  w_den;

    t_ratio_ctl        w_ctl [0:Q_W];
    logic [DEN_W-1:0]  w_rem [0:Q_W];
    logic [Q_W-1:0]    w_q   [0:Q_W];
    logic [C:0]        w_ex  [0:Q_W];
    logic [C:0]        w_ey  [0:Q_W];

    assign o_cfg_ready = 1'b1;
    assign o_busy      = r_busy;
    assign w_accept    = i_start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_X: r_start_x <= i_cfg_data;
                REG_START_Y: r_start_y <= i_cfg_data;
                REG_END_X:   r_end_x   <= i_cfg_data;
                REG_END_Y:   r_end_y   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    psd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .i_end_x   (r_end_x),
        .i_end_y   (r_end_y),
        .o_ctl     (w_ctl[0]),
        .o_rem     (w_rem[0]),
        .o_ex      (w_ex[0]),
        .o_ey      (w_ey[0]),
        .o_dx      (w_dx),
        .o_dy      (w_dy),
        .o_den     (w_den)
    );

    assign w_q[0] = '0;

    // one quotient bit per cell, MSB first
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        psd_cell #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_den   (w_den),
            .i_ctl   (w_ctl[k]),
            .i_rem   (w_rem[k]),
            .i_q     (w_q[k]),
            .i_ex    (w_ex[k]),
            .i_ey    (w_ey[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_q     (w_q[k+1]),
            .o_ex    (w_ex[k+1]),
            .o_ey    (w_ey[k+1])
        );
    end

    psd_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl[Q_W]),
        .i_q        (w_q[Q_W]),
        .i_ex       (w_ex[Q_W]),
        .i_ey       (w_ey[Q_W]),
        .i_dx       (w_dx),
        .i_dy       (w_dy),
        .i_start_x  (r_start_x),
        .i_start_y  (r_start_y),
        .o_valid    (o_valid),
        .o_ratio    (o_ratio),
        .o_near_x   (o_near_x),
        .o_near_y   (o_near_y),
        .o_offset_x (o_offset_x),
        .o_offset_y (o_offset_y),
        .o_dist_sqr (o_dist_sqr)
    );

    assign w_div_live = w_ctl[Q_W].valid && (w_ctl[Q_W].sat == SAT_NONE);

    `PSD_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(w_accept, LAT), "stray strobe")
    `PSD_ASSERT_IMP(a_final_rem, i_clk, i_rst_n, w_div_live, w_rem[Q_W] < w_den, "rem >= den")

endmodule

`default_nettype wire
